// ===== hdl/aabb_plane_set_cull_unit_macros.svh =====
// assertion macros for the plane set cull unit
`ifndef AABB_PLANE_SET_CULL_UNIT_MACROS_SVH
`define AABB_PLANE_SET_CULL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define APSC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");
`define APSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define APSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define APSC_ASSERT(lbl, clk, rst_n, prop)
`define APSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define APSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/apsc_pkg.sv =====
// ----------------------------------------------------------------------------
// apsc_pkg
// Shared constants and the token type that travels down the plane cell chain.
// ----------------------------------------------------------------------------
package apsc_pkg;

	localparam int PLANES   = 8;
	localparam int MASK_W   = 8;
	localparam int CELLS    = (PLANES < MASK_W) ? PLANES : MASK_W;
	localparam int PIDX_W   = 3;
	localparam int COEF_W   = 32;
	localparam int PROD_W   = 2 * COEF_W;
	localparam int SUM_W    = PROD_W + 3;
	localparam int FRAC_W   = 16;
	localparam int S_DATA_W = 240;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 16;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_CULL = 1'b1;

	localparam logic [1:0] SEL_NX  = 2'd0;
	localparam logic [1:0] SEL_NY  = 2'd1;
	localparam logic [1:0] SEL_NZ  = 2'd2;
	localparam logic [1:0] SEL_OFF = 2'd3;

	typedef struct packed {
		logic                     mode;
		logic [PIDX_W-1:0]        plane_index;
		logic [1:0]               coef_select;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [COEF_W-1:0] box_min_x;
		logic signed [COEF_W-1:0] box_min_y;
		logic signed [COEF_W-1:0] box_min_z;
		logic signed [COEF_W-1:0] box_max_x;
		logic signed [COEF_W-1:0] box_max_y;
		logic signed [COEF_W-1:0] box_max_z;
		logic [MASK_W-1:0]        plane_mask;
		logic [MASK_W-1:0]        remain;
		logic                     rej;
	} tok_t;

endpackage

// ===== hdl/apsc_cell.sv =====
// ----------------------------------------------------------------------------
// apsc_cell
// One plane of the set: holds its coefficients, takes loads addressed to it
// and tests a passing box in two stages (products, then sum and compare).
// ----------------------------------------------------------------------------
module apsc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [apsc_pkg::PIDX_W-1:0] cell_idx,
	input  logic                        in_valid,
	input  apsc_pkg::tok_t              in_tok,
	output logic                        out_valid,
	output apsc_pkg::tok_t              out_tok
);
	import apsc_pkg::*;

	logic signed [COEF_W-1:0] nx_q, ny_q, nz_q, off_q;

	logic signed [COEF_W-1:0] rx, ry, rz, ax, ay, az;
	logic                     active;

	logic                     v_s1;
	tok_t                     tok_s1;
	logic                     active_s1;
	logic signed [COEF_W-1:0] off_s1;
	logic signed [PROD_W-1:0] prx_s1, pry_s1, prz_s1, pax_s1, pay_s1, paz_s1;

	logic signed [SUM_W-1:0]  off_w, sum_r, sum_a;
	logic                     hit_rej, hit_clr;
	tok_t                     tok_nxt;

	logic                     v_s2;
	tok_t                     tok_s2;

	// reject corner takes the min where the normal points negative
	assign rx = nx_q[COEF_W-1] ? in_tok.box_min_x : in_tok.box_max_x;
	assign ry = ny_q[COEF_W-1] ? in_tok.box_min_y : in_tok.box_max_y;
	assign rz = nz_q[COEF_W-1] ? in_tok.box_min_z : in_tok.box_max_z;
	assign ax = nx_q[COEF_W-1] ? in_tok.box_max_x : in_tok.box_min_x;
	assign ay = ny_q[COEF_W-1] ? in_tok.box_max_y : in_tok.box_min_y;
	assign az = nz_q[COEF_W-1] ? in_tok.box_max_z : in_tok.box_min_z;

	assign active = (in_tok.mode == MODE_CULL) && in_tok.plane_mask[cell_idx] && !in_tok.rej;

	// coefficient store, written as a load beat passes this cell
	always_ff @(posedge clk) begin
		if (adv && in_valid && (in_tok.mode == MODE_LOAD) && (in_tok.plane_index == cell_idx)) begin
			unique case (in_tok.coef_select)
				SEL_NX:  nx_q  <= in_tok.coef_value;
				SEL_NY:  ny_q  <= in_tok.coef_value;
				SEL_NZ:  nz_q  <= in_tok.coef_value;
				SEL_OFF: off_q <= in_tok.coef_value;
				default: nx_q  <= nx_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1    <= in_tok;
			active_s1 <= in_valid && active;
			off_s1    <= off_q;
			prx_s1    <= nx_q * rx;
			pry_s1    <= ny_q * ry;
			prz_s1    <= nz_q * rz;
			pax_s1    <= nx_q * ax;
			pay_s1    <= ny_q * ay;
			paz_s1    <= nz_q * az;
		end
	end

	// offset scaled to the product format
	assign off_w = SUM_W'(off_s1) <<< FRAC_W;
	assign sum_r = SUM_W'(prx_s1) + SUM_W'(pry_s1) + SUM_W'(prz_s1) - off_w;
	assign sum_a = SUM_W'(pax_s1) + SUM_W'(pay_s1) + SUM_W'(paz_s1) - off_w;

	assign hit_rej = sum_r[SUM_W-1] || (sum_r == '0);
	assign hit_clr = !sum_a[SUM_W-1];

	always_comb begin
		tok_nxt = tok_s1;
		if (active_s1) begin
			if (hit_rej) begin
				tok_nxt.rej = 1'b1;
			end else if (hit_clr) begin
				tok_nxt.remain[cell_idx] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2 <= tok_nxt;
		end
	end

	assign out_valid = v_s2;
	assign out_tok   = tok_s2;

endmodule

// ===== hdl/aabb_plane_set_cull_unit.sv =====
// an input beat passes through every plane cell and then the output register to become a result beat
// throughput: one beat per cycle; the chain of plane cells advances as a whole
// and stalls only while a result beat waits on the output
// loads travel the chain too, so each plane changes in order with the boxes
// reset clears all valid flags; plane coefficients hold no value until loaded
// ----------------------------------------------------------------------------
// aabb_plane_set_cull_unit
// Box against plane set culling with the reject/accept corner test, one cell
// per plane in a chain.
// ----------------------------------------------------------------------------
`include "aabb_plane_set_cull_unit_macros.svh"

module aabb_plane_set_cull_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// plane_index, coef_select, coef_value, box_min_x, box_min_y, box_min_z,
	// box_max_x, box_max_y, box_max_z, plane_mask, zero fill
	input  logic [apsc_pkg::S_DATA_W-1:0] s_axis_tdata,
	// mode
	input  logic [apsc_pkg::S_USER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// rejected, remaining_mask, accepted, zero fill
	output logic [apsc_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import apsc_pkg::*;

	logic              adv;
	logic              chain_v   [CELLS+1];
	tok_t              chain_tok [CELLS+1];
	tok_t              last_tok;

	logic              out_valid_q;
	logic              rej_q;
	logic              acc_q;
	logic [MASK_W-1:0] mask_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	assign chain_v[0]               = s_axis_tvalid;
	assign chain_tok[0].mode        = s_axis_tuser[0];
	assign chain_tok[0].plane_index = s_axis_tdata[2:0];
	assign chain_tok[0].coef_select = s_axis_tdata[4:3];
	assign chain_tok[0].coef_value  = s_axis_tdata[36:5];
	assign chain_tok[0].box_min_x   = s_axis_tdata[68:37];
	assign chain_tok[0].box_min_y   = s_axis_tdata[100:69];
	assign chain_tok[0].box_min_z   = s_axis_tdata[132:101];
	assign chain_tok[0].box_max_x   = s_axis_tdata[164:133];
	assign chain_tok[0].box_max_y   = s_axis_tdata[196:165];
	assign chain_tok[0].box_max_z   = s_axis_tdata[228:197];
	assign chain_tok[0].plane_mask  = s_axis_tdata[236:229];
	assign chain_tok[0].remain      = s_axis_tdata[236:229];
	assign chain_tok[0].rej         = 1'b0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		apsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cell_idx  (PIDX_W'(k)),
			.in_valid  (chain_v[k]),
			.in_tok    (chain_tok[k]),
			.out_valid (chain_v[k+1]),
			.out_tok   (chain_tok[k+1])
		);
	end

	assign last_tok = chain_tok[CELLS];

	// only cull beats leave the chain as results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_v[CELLS] && (last_tok.mode == MODE_CULL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rej_q  <= last_tok.rej;
			mask_q <= last_tok.remain;
			acc_q  <= !last_tok.rej && (last_tok.remain == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(M_DATA_W - MASK_W - 2)'(0), acc_q, mask_q, rej_q};

	`APSC_ASSERT_IMPL(a_acc_excl, clk, arst_n, out_valid_q && acc_q, !rej_q && (mask_q == '0))
	`APSC_ASSERT_NEXT(a_cull_out, clk, arst_n, adv && chain_v[CELLS] && (last_tok.mode == MODE_CULL), out_valid_q)
	`APSC_ASSERT(a_no_mask_grow, clk, arst_n, !chain_v[CELLS] || ((last_tok.remain & ~last_tok.plane_mask) == '0))

endmodule

// ===== tb/sv/aabb_plane_set_cull_unit_tb.sv =====
// ----------------------------------------------------------------------------
// aabb_plane_set_cull_unit_tb
// Loads plane coefficients and streams boxes through the cull unit with bursty
// input and a stalling output. Every verdict beat is compared with an expected
// verdict, given with a directed row or worked out from a shadow plane table.
// ----------------------------------------------------------------------------
module aabb_plane_set_cull_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import apsc_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic signed [COEF_W-1:0] Q_ONE = 32'sh0001_0000;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic              mode;
		logic [PIDX_W-1:0] plane_index;
		logic [1:0]        coef_select;
		coef_t             coef_value;
		coef_t             box_min_x;
		coef_t             box_min_y;
		coef_t             box_min_z;
		coef_t             box_max_x;
		coef_t             box_max_y;
		coef_t             box_max_z;
		logic [MASK_W-1:0] plane_mask;
	} box_item_t;

	typedef struct packed {
		logic              rejected;
		logic [MASK_W-1:0] remaining_mask;
		logic              accepted;
	} verdict_t;

	typedef struct {
		box_item_t item;
		bit        typed;
		verdict_t  verdict;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// plane_index, coef_select, coef_value, box_min_x/y/z, box_max_x/y/z,
	// plane_mask, zero fill
	logic [S_DATA_W-1:0] s_axis_tdata;
	// mode
	logic [S_USER_W-1:0] s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// rejected, remaining_mask, accepted, zero fill
	logic [M_DATA_W-1:0] m_axis_tdata;

	// shadow plane table and which coefficients have been loaded
	coef_t             plane_nx  [PLANES];
	coef_t             plane_ny  [PLANES];
	coef_t             plane_nz  [PLANES];
	coef_t             plane_off [PLANES];
	logic [PLANES-1:0] seen_nx, seen_ny, seen_nz, seen_off;

	verdict_t  expected_verdicts[$];
	stim_row_t directed_rows[$];
	verdict_t  seen_verdict;
	verdict_t  due_verdict;
	int        error_count = 0;
	int        cycle_count = 0;
	int        burst_left;

	aabb_plane_set_cull_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sign of n.p - offset, all exact in 72 bits
	function automatic int plane_sign(coef_t nx, coef_t ny, coef_t nz, coef_t off,
			coef_t px, coef_t py, coef_t pz);
		logic signed [71:0] wnx, wny, wnz, woff, wpx, wpy, wpz, sum;
		wnx = nx; wny = ny; wnz = nz; woff = off;
		wpx = px; wpy = py; wpz = pz;
		sum = wnx * wpx + wny * wpy + wnz * wpz - (woff <<< FRAC_W);
		if (sum < 0)
			return -1;
		return (sum == 0) ? 0 : 1;
	endfunction

	function automatic verdict_t cull_box(box_item_t it);
		verdict_t v;
		coef_t    rx, ry, rz, ax, ay, az;
		bit       stopped;
		v.rejected       = 1'b0;
		v.remaining_mask = it.plane_mask;
		stopped          = 1'b0;
		for (int k = 0; k < CELLS; k++) begin
			if (!stopped && it.plane_mask[k]) begin
				// reject corner is the one furthest along the normal
				rx = plane_nx[k][COEF_W-1] ? it.box_min_x : it.box_max_x;
				ry = plane_ny[k][COEF_W-1] ? it.box_min_y : it.box_max_y;
				rz = plane_nz[k][COEF_W-1] ? it.box_min_z : it.box_max_z;
				ax = plane_nx[k][COEF_W-1] ? it.box_max_x : it.box_min_x;
				ay = plane_ny[k][COEF_W-1] ? it.box_max_y : it.box_min_y;
				az = plane_nz[k][COEF_W-1] ? it.box_max_z : it.box_min_z;
				if (plane_sign(plane_nx[k], plane_ny[k], plane_nz[k], plane_off[k],
						rx, ry, rz) <= 0) begin
					v.rejected = 1'b1;
					stopped    = 1'b1;
				end else if (plane_sign(plane_nx[k], plane_ny[k], plane_nz[k],
						plane_off[k], ax, ay, az) >= 0) begin
					v.remaining_mask[k] = 1'b0;
				end
			end
		end
		v.accepted = !v.rejected && (v.remaining_mask == '0);
		return v;
	endfunction

	function automatic logic [S_DATA_W-1:0] pack_beat(box_item_t it);
		logic [S_DATA_W-1:0] d;
		d = {3'b000, it.plane_mask, it.box_max_z, it.box_max_y, it.box_max_x,
			it.box_min_z, it.box_min_y, it.box_min_x, it.coef_value,
			it.coef_select, it.plane_index};
		return d;
	endfunction

	// mix of raw values, coarse grid points and extremes so that ties happen
	function automatic coef_t pick_value();
		case ($urandom_range(0, 5))
			0, 1: return coef_t'($urandom);
			2: return coef_t'(($urandom_range(0, 8) - 4) * Q_ONE);
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					3: return 32'shffff_ffff;
					default: return Q_ONE;
				endcase
			end
			4: return coef_t'($urandom_range(0, 2046) - 1023);
			default: return coef_t'(($urandom_range(0, 16) - 8) * (Q_ONE >>> 1));
		endcase
	endfunction

	function automatic stim_row_t load_row(int idx, logic [1:0] sel, coef_t val);
		stim_row_t r;
		r.item             = '1;
		r.item.mode        = MODE_LOAD;
		r.item.plane_index = idx[PIDX_W-1:0];
		r.item.coef_select = sel;
		r.item.coef_value  = val;
		r.typed            = 1'b0;
		r.verdict          = '0;
		return r;
	endfunction

	function automatic stim_row_t cull_row(coef_t mnx, coef_t mxx, coef_t mny, coef_t mxy,
			coef_t mnz, coef_t mxz, logic [MASK_W-1:0] mask, bit typed,
			logic rej, logic [MASK_W-1:0] rem, logic acc);
		stim_row_t r;
		r.item            = '1;
		r.item.mode       = MODE_CULL;
		r.item.box_min_x  = mnx;
		r.item.box_max_x  = mxx;
		r.item.box_min_y  = mny;
		r.item.box_max_y  = mxy;
		r.item.box_min_z  = mnz;
		r.item.box_max_z  = mxz;
		r.item.plane_mask = mask;
		r.typed           = typed;
		r.verdict         = '{rej, rem, acc};
		return r;
	endfunction

	task automatic send_item(input box_item_t it, input bit typed, input verdict_t verdict);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pack_beat(it);
		s_axis_tuser  <= it.mode;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (it.mode == MODE_LOAD) begin
			if (int'(it.plane_index) < PLANES) begin
				case (it.coef_select)
					SEL_NX: begin
						plane_nx[it.plane_index] = it.coef_value;
						seen_nx[it.plane_index]  = 1'b1;
					end
					SEL_NY: begin
						plane_ny[it.plane_index] = it.coef_value;
						seen_ny[it.plane_index]  = 1'b1;
					end
					SEL_NZ: begin
						plane_nz[it.plane_index] = it.coef_value;
						seen_nz[it.plane_index]  = 1'b1;
					end
					default: begin
						plane_off[it.plane_index] = it.coef_value;
						seen_off[it.plane_index]  = 1'b1;
					end
				endcase
			end
		end else begin
			expected_verdicts.push_back(typed ? verdict : cull_box(it));
		end
	endtask

	// bursts of random length separated by random gaps
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic note_error(input string what, input verdict_t want, input verdict_t got);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] %s: expected rej=%0b mask=%02h acc=%0b, got rej=%0b mask=%02h acc=%0b",
				$realtime, what, want.rejected, want.remaining_mask, want.accepted,
				got.rejected, got.remaining_mask, got.accepted);
	endtask

	// receiver: the ready pattern switches among four styles, picked at random
	initial begin
		int style;
		int run_left;
		logic level;
		m_axis_tready <= 1'b0;
		style    = 0;
		run_left = 0;
		level    = 1'b1;
		forever begin
			@(posedge clk);
			if (cycle_count % 300 == 0)
				style = $urandom_range(0, 3);
			case (style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= (cycle_count % 4 == 0);
				default: begin
					if (run_left == 0) begin
						run_left = $urandom_range(1, 20);
						level    = ~level;
					end
					run_left--;
					m_axis_tready <= level;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_verdict.rejected       = m_axis_tdata[0];
			seen_verdict.remaining_mask = m_axis_tdata[MASK_W:1];
			seen_verdict.accepted       = m_axis_tdata[MASK_W+1];
			if (expected_verdicts.size() == 0) begin
				note_error("unexpected verdict beat", '0, seen_verdict);
			end else begin
				due_verdict = expected_verdicts.pop_front();
				if (seen_verdict !== due_verdict)
					note_error("verdict mismatch", due_verdict, seen_verdict);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		box_item_t         it;
		logic [255:0]      raw_bits;
		coef_t             lo, hi;
		logic [PLANES-1:0] ready_planes;
		logic [MASK_W-1:0] mask;
		int                pick;

		burst_left    = 0;
		seen_nx       = '0;
		seen_ny       = '0;
		seen_nz       = '0;
		seen_off      = '0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plane 0: x = 0; plane 1: extreme coefficients
		directed_rows.push_back(load_row(0, SEL_NX, Q_ONE));
		directed_rows.push_back(load_row(0, SEL_NY, 0));
		directed_rows.push_back(load_row(0, SEL_NZ, 0));
		directed_rows.push_back(load_row(0, SEL_OFF, 0));
		directed_rows.push_back(load_row(1, SEL_NX, 32'sh8000_0000));
		directed_rows.push_back(load_row(1, SEL_NY, 32'sh7fff_ffff));
		directed_rows.push_back(load_row(1, SEL_NZ, 32'shffff_ffff));
		directed_rows.push_back(load_row(1, SEL_OFF, 32'sh8000_0000));
		// empty mask, then boxes on both sides of x = 0 and touching it
		directed_rows.push_back(cull_row(Q_ONE, 2*Q_ONE, -5*Q_ONE, 5*Q_ONE, -5*Q_ONE,
			5*Q_ONE, 8'h00, 1, 1'b0, 8'h00, 1'b1));
		directed_rows.push_back(cull_row(Q_ONE, 2*Q_ONE, -5*Q_ONE, 5*Q_ONE, -5*Q_ONE,
			5*Q_ONE, 8'h01, 1, 1'b0, 8'h00, 1'b1));
		directed_rows.push_back(cull_row(-2*Q_ONE, -Q_ONE, -5*Q_ONE, 5*Q_ONE, -5*Q_ONE,
			5*Q_ONE, 8'h01, 1, 1'b1, 8'h01, 1'b0));
		directed_rows.push_back(cull_row(-Q_ONE, 0, 0, 0, 0, 0, 8'h01, 1, 1'b1, 8'h01, 1'b0));
		directed_rows.push_back(cull_row(0, Q_ONE, 0, 0, 0, 0, 8'h01, 1, 1'b0, 8'h00, 1'b1));
		directed_rows.push_back(cull_row(-Q_ONE, Q_ONE, 0, 0, 0, 0, 8'h01, 1,
			1'b0, 8'h01, 1'b0));
		// inverted box
		directed_rows.push_back(cull_row(2*Q_ONE, -2*Q_ONE, Q_ONE, -Q_ONE, 0, 0, 8'h01, 1,
			1'b1, 8'h01, 1'b0));
		directed_rows.push_back(cull_row(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 8'h03, 0, 0, 0, 0));
		directed_rows.push_back(cull_row(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 8'h03, 0, 0, 0, 0));
		directed_rows.push_back(cull_row(-3*Q_ONE, 5*Q_ONE, -Q_ONE, 2*Q_ONE, -7, 9,
			8'h02, 0, 0, 0, 0));
		// plane 0 clears its bit, then plane 1 rejects on a tie
		directed_rows.push_back(cull_row(Q_ONE, 2*Q_ONE, -Q_ONE, 0, 0, 0, 8'h03, 0, 0, 0, 0));
		// offset reload lands between boxes
		directed_rows.push_back(load_row(0, SEL_OFF, 2*Q_ONE));
		directed_rows.push_back(cull_row(Q_ONE, 3*Q_ONE, 0, 0, 0, 0, 8'h01, 1,
			1'b0, 8'h01, 1'b0));
		directed_rows.push_back(cull_row(2*Q_ONE, 3*Q_ONE, 0, 0, 0, 0, 8'h01, 1,
			1'b0, 8'h00, 1'b1));

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].verdict);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pace_sender();
			raw_bits = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			it = raw_bits[$bits(box_item_t)-1:0];
			if ($urandom_range(0, 7) == 0) begin
				it.mode        = MODE_LOAD;
				it.plane_index = PIDX_W'($urandom_range(0, 7));
				it.coef_select = 2'($urandom_range(0, 3));
				it.coef_value  = pick_value();
			end else begin
				it.mode = MODE_CULL;
				for (int a = 0; a < 3; a++) begin
					lo = pick_value();
					hi = pick_value();
					// mostly well-formed boxes, some left inverted
					if (lo > hi && $urandom_range(0, 9) != 0) begin
						lo = lo ^ hi;
						hi = lo ^ hi;
						lo = lo ^ hi;
					end
					case (a)
						0: begin it.box_min_x = lo; it.box_max_x = hi; end
						1: begin it.box_min_y = lo; it.box_max_y = hi; end
						default: begin it.box_min_z = lo; it.box_max_z = hi; end
					endcase
				end
				// only planes with all four coefficients loaded may be tested
				ready_planes = seen_nx & seen_ny & seen_nz & seen_off;
				pick = $urandom_range(0, 3);
				if (pick == 0)
					mask = MASK_W'(ready_planes);
				else if (pick == 1)
					mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
				else
					mask = MASK_W'($urandom);
				it.plane_mask = mask & MASK_W'(ready_planes);
			end
			send_item(it, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/apsc_pkg.sv
hdl/apsc_cell.sv
hdl/aabb_plane_set_cull_unit.sv
tb/sv/aabb_plane_set_cull_unit_tb.sv
